>>> rtl/core/sbbf_pkg.sv
// Shared types, constants and salt table of the split-block Bloom filter.
package sbbf_pkg;

    localparam int SBBF_MAX_BLOCKS_DEFAULT = 1024;

    localparam int SBBF_WORDS      = 8;
    localparam int SBBF_WORD_W     = 32;
    localparam int SBBF_BLOCK_W    = SBBF_WORDS * SBBF_WORD_W;
    localparam int SBBF_SEL_W      = 5;
    localparam int SBBF_SEL_SHIFT  = SBBF_WORD_W - SBBF_SEL_W;
    localparam int SBBF_HASH_W     = 64;
    localparam int SBBF_HALF_W     = SBBF_HASH_W / 2;

    // The modulo unit retires this many dividend bits per cycle.
    localparam int SBBF_DIV_BITS   = 8;
    localparam int SBBF_DIV_STEPS  = SBBF_HALF_W / SBBF_DIV_BITS;
    localparam int SBBF_STEP_W     = $clog2(SBBF_DIV_STEPS);
    // Two salt products are formed in each of those cycles.
    localparam int SBBF_MULS       = SBBF_WORDS / SBBF_DIV_STEPS;

    localparam int                 SBBF_CFG_W     = 11;
    localparam logic [SBBF_CFG_W-1:0] SBBF_CFG_RESET = 11'd1024;

    localparam logic [SBBF_WORD_W-1:0] SBBF_SALTS [SBBF_WORDS] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    typedef enum logic {
        SBBF_OP_INSERT = 1'b0,
        SBBF_OP_QUERY  = 1'b1
    } sbbf_op_t;

    typedef enum logic [2:0] {
        SBBF_ST_CLEAR,
        SBBF_ST_IDLE,
        SBBF_ST_CALC,
        SBBF_ST_READ,
        SBBF_ST_FINISH
    } sbbf_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic rd;
        logic wr;
        logic clr;
    } sbbf_cmd_t;

    typedef struct packed {
        logic last_step;
        logic clr_last;
        logic out_free;
    } sbbf_status_t;

endpackage

>>> rtl/core/sbbf_ctrl.sv
// Controller state machine of the split-block Bloom filter.
module sbbf_ctrl
    import sbbf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  sbbf_status_t status,
    output sbbf_cmd_t    cmd
);

    sbbf_state_t state_reg;
    sbbf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SBBF_ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SBBF_ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = SBBF_ST_IDLE;
                end
            end
            SBBF_ST_IDLE: begin
                if (s_valid) begin
                    state_next = SBBF_ST_CALC;
                end
            end
            SBBF_ST_CALC: begin
                if (status.last_step) begin
                    state_next = SBBF_ST_READ;
                end
            end
            SBBF_ST_READ: begin
                state_next = SBBF_ST_FINISH;
            end
            SBBF_ST_FINISH: begin
                if (status.out_free) begin
                    state_next = SBBF_ST_IDLE;
                end
            end
            default: begin
                state_next = SBBF_ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            SBBF_ST_CLEAR: begin
                cmd.clr = 1'b1;
            end
            SBBF_ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            SBBF_ST_CALC: begin
                cmd.step = 1'b1;
            end
            SBBF_ST_READ: begin
                cmd.rd = 1'b1;
            end
            SBBF_ST_FINISH: begin
                cmd.wr = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/sbbf_datapath.sv
// Datapath of the split-block Bloom filter: modulo unit, salt multipliers,
// block memory and result register.
module sbbf_datapath
    import sbbf_pkg::*;
#(
    parameter int MAX_BLOCKS = SBBF_MAX_BLOCKS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [SBBF_CFG_W-1:0]  cfg_wr_data,
    input  logic                   s_opcode,
    input  logic [SBBF_HASH_W-1:0] s_hash,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_may_contain,
    input  sbbf_cmd_t              cmd,
    output sbbf_status_t           status
);

    localparam int NW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int EW = (NW > SBBF_CFG_W) ? NW : SBBF_CFG_W;

    logic [SBBF_CFG_W-1:0]  blocks_in_use_reg;
    logic                   opcode_reg;
    logic [SBBF_HALF_W-1:0] upper_reg;
    logic [SBBF_HALF_W-1:0] key_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          rem_reg;
    logic [NW-1:0]          rem_next;
    logic [SBBF_STEP_W-1:0] cnt_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic [SBBF_WORD_W-1:0] mask_reg [SBBF_WORDS];
    logic [SBBF_BLOCK_W-1:0] mask_flat;
    logic [SBBF_BLOCK_W-1:0] rd_data_reg;
    logic [SBBF_BLOCK_W-1:0] mem [MAX_BLOCKS];
    logic                   m_valid_reg;
    logic                   m_may_contain_reg;

    logic [EW-1:0]          cfg_ext;
    logic [NW-1:0]          n_eff;
    logic [SBBF_WORD_W-1:0] prod [SBBF_MULS];
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SBBF_BLOCK_W-1:0] mem_wdata;
    logic                   all_set;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_in_use_reg <= SBBF_CFG_RESET;
        end else if (cfg_wr_en) begin
            blocks_in_use_reg <= cfg_wr_data;
        end
    end

    // Zero blocks count as one, counts above the store size are clamped.
    always_comb begin
        cfg_ext = EW'(blocks_in_use_reg);
        if (cfg_ext == '0) begin
            n_eff = NW'(1);
        end else if (cfg_ext > EW'(MAX_BLOCKS)) begin
            n_eff = NW'(MAX_BLOCKS);
        end else begin
            n_eff = cfg_ext[NW-1:0];
        end
    end

    // Restoring remainder, most significant dividend bits first.
    always_comb begin
        logic [NW:0] t;
        rem_next = rem_reg;
        t        = '0;
        for (int i = 0; i < SBBF_DIV_BITS; i++) begin
            t = {rem_next, upper_reg[SBBF_HALF_W-1-i]};
            if (t >= {1'b0, n_reg}) begin
                t = t - {1'b0, n_reg};
            end
            rem_next = t[NW-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < SBBF_MULS; j++) begin
            prod[j] = key_reg * SBBF_SALTS[SBBF_MULS * int'(cnt_reg) + j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg   <= NW'(1);
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.load) begin
            n_reg   <= n_eff;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            opcode_reg <= s_opcode;
            upper_reg  <= s_hash[SBBF_HASH_W-1:SBBF_HALF_W];
            key_reg    <= s_hash[SBBF_HALF_W-1:0];
        end else if (cmd.step) begin
            upper_reg <= upper_reg << SBBF_DIV_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            for (int j = 0; j < SBBF_MULS; j++) begin
                mask_reg[SBBF_MULS * int'(cnt_reg) + j] <=
                    SBBF_WORD_W'(1) << prod[j][SBBF_WORD_W-1:SBBF_SEL_SHIFT];
            end
        end
    end

    always_comb begin
        for (int w = 0; w < SBBF_WORDS; w++) begin
            mask_flat[w*SBBF_WORD_W +: SBBF_WORD_W] = mask_reg[w];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign all_set   = ((rd_data_reg & mask_flat) == mask_flat);
    assign mem_we    = cmd.clr || (cmd.wr && (opcode_reg == SBBF_OP_INSERT));
    assign mem_waddr = cmd.clr ? clr_addr_reg : rem_reg[AW-1:0];
    assign mem_wdata = cmd.clr ? '0 : (rd_data_reg | mask_flat);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[rem_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.wr) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            m_may_contain_reg <= (opcode_reg == SBBF_OP_QUERY) && all_set;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_may_contain = m_may_contain_reg;

    assign status.last_step = (cnt_reg == SBBF_STEP_W'(SBBF_DIV_STEPS - 1));
    assign status.clr_last  = (clr_addr_reg == AW'(MAX_BLOCKS - 1));
    assign status.out_free  = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < n_reg)
        else $error("remainder reached the divisor");

    a_wr_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> (!m_valid_reg || m_ready))
        else $error("result written over an untaken result");

    a_wr_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |=> m_valid_reg)
        else $error("finished item did not raise its result");

    a_mask_eight_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> ($countones(mask_flat) == SBBF_WORDS))
        else $error("probe mask does not hold one bit per word");
`endif

endmodule

>>> rtl/core/split_block_bloom_filter_unit.sv
// Split-block Bloom filter: each transfer on the s_ channel carries an opcode
// and a 64-bit hash; the upper 32 hash bits modulo the effective block count
// (blocks_in_use, with 0 read as 1 and values above MAX_BLOCKS clamped) pick
// one 256-bit block, and the lower 32 bits, multiplied by eight fixed salts,
// pick one bit in each of its eight 32-bit words. An insert sets those bits,
// a query reports on the m_ channel whether all eight were already set; every
// item, insert or query, yields exactly one result transfer. The block works
// on one item at a time, in these steps: accept it, run the modulo unit (it
// retires eight dividend bits per cycle while two salt multipliers build the
// probe mask alongside), read the block from memory, then write it back and
// load the result register. A waiting result does not stop the next item from
// being accepted; only the write-back step waits for the result register to
// drain. After reset the block memory is cleared one block per cycle, and no
// item is accepted until that pass ends.
// blocks_in_use may be written at any time the block is idle; a new count
// does not clear the filter, and old contents are addressed with the new
// modulus.
module split_block_bloom_filter_unit
    import sbbf_pkg::*;
#(
    parameter int MAX_BLOCKS = SBBF_MAX_BLOCKS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration: the one register, blocks_in_use.
    input  logic                   cfg_wr_en,
    input  logic [SBBF_CFG_W-1:0]  cfg_wr_data,

    // Input channel.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [SBBF_HASH_W-1:0] s_hash,

    // Result channel.
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_may_contain
);

    sbbf_cmd_t    cmd;
    sbbf_status_t status;

    // The controller sequences clear, accept, modulo steps, read and
    // write-back; the datapath acts on its commands, on configuration writes and on m_ready.
    sbbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sbbf_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_opcode      (s_opcode),
        .s_hash        (s_hash),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_may_contain (m_may_contain),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
